// ===== hdl/ahrp_pkg.sv =====
// shared types, constants and the hex digit decode for the record parser
`default_nettype none

package ahrp_pkg;

	localparam int unsigned REC_BYTES = 42;
	localparam int unsigned POS_W = 6;

	localparam logic [7:0] CR_BYTE = 8'h0D;
	localparam logic [7:0] ACTION_BYTE = 8'h57;

	localparam logic [31:0] MARKER_RESET = 32'h414C7E46;
	localparam logic [16:0] MEMSIZE_RESET = 17'd4096;

	// configuration register indexes
	localparam logic [1:0] CFG_MARKER = 2'd0;
	localparam logic [1:0] CFG_MEMSIZE = 2'd1;

	// field boundaries as byte positions
	localparam logic [POS_W-1:0] POS_OFFSET = 6'd4;
	localparam logic [POS_W-1:0] POS_ACTION = 6'd8;
	localparam logic [POS_W-1:0] POS_LAST = 6'd41;
	localparam logic [POS_W-1:0] POS_SAT = 6'd42;

	// status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_LENGTH = 3'd1;
	localparam logic [2:0] ST_OFFHEX = 3'd2;
	localparam logic [2:0] ST_DATAHEX = 3'd3;
	localparam logic [2:0] ST_MARKER = 3'd4;
	localparam logic [2:0] ST_ACTION = 3'd5;
	localparam logic [2:0] ST_ALIGN = 3'd6;
	localparam logic [2:0] ST_RANGE = 3'd7;

	typedef struct packed {
		logic        offhex;
		logic        datahex;
		logic        marker;
		logic        action;
	} err_flags_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] record_offset;
		logic [63:0] data_low;
		logic [63:0] data_high;
	} result_t;

	typedef struct packed {
		logic        bad;
		logic [3:0]  value;
	} hex_t;

	// upper-case hex digit decode; bad digits read as zero
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.bad = 1'b0;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = 4'(c - 8'h37);
		end else begin
			h.bad = 1'b1;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ahrp_field_unit.sv =====
// record field state: position, offset and data shifts, error flags, result on carriage return
`default_nettype none

module ahrp_field_unit
	import ahrp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [31:0] marker_word,
	input  wire logic [16:0] memory_size,
	output logic             push,
	output result_t          result
);

	logic [POS_W-1:0] pos_q;
	logic [3:0]       nib_q;
	logic [15:0]      off_q;
	logic [63:0]      lo_q;
	logic [63:0]      hi_q;
	err_flags_t       err_q;

	logic             is_cr;
	hex_t             hx;
	logic [7:0]       want;
	logic [7:0]       data_byte;

	assign is_cr = (rx_byte == CR_BYTE);
	assign push = accept && is_cr;
	assign hx = hex_digit(rx_byte);
	assign data_byte = {nib_q, hx.value};

	// expected marker byte, first byte in the top bits
	always_comb begin
		unique case (pos_q[1:0])
			2'd0: want = marker_word[31:24];
			2'd1: want = marker_word[23:16];
			2'd2: want = marker_word[15:8];
			default: want = marker_word[7:0];
		endcase
	end

	// result of the record ended by this carriage return
	always_comb begin
		logic [15:0] off;
		logic [63:0] lo;
		logic [63:0] hi;
		off = err_q.offhex ? 16'd0 : off_q;
		lo = err_q.datahex ? 64'd0 : lo_q;
		hi = err_q.datahex ? 64'd0 : hi_q;
		result.record_offset = off;
		result.data_low = lo;
		result.data_high = hi;
		if (pos_q != POS_LAST) begin
			result.status = ST_LENGTH;
			result.record_offset = 16'd0;
			result.data_low = 64'd0;
			result.data_high = 64'd0;
		end else if (err_q.offhex) begin
			result.status = ST_OFFHEX;
		end else if (err_q.datahex) begin
			result.status = ST_DATAHEX;
		end else if (err_q.marker) begin
			result.status = ST_MARKER;
		end else if (err_q.action) begin
			result.status = ST_ACTION;
		end else if (off[3:0] != 4'd0) begin
			result.status = ST_ALIGN;
		end else if ({1'b0, off} >= memory_size) begin
			result.status = ST_RANGE;
		end else begin
			result.status = ST_OK;
		end
	end

	// per-byte state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			nib_q <= '0;
			off_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			err_q <= '0;
		end else if (accept) begin
			if (is_cr) begin
				pos_q <= '0;
				nib_q <= '0;
				off_q <= '0;
				lo_q <= '0;
				hi_q <= '0;
				err_q <= '0;
			end else begin
				if (pos_q < POS_OFFSET) begin
					if (rx_byte != want) begin
						err_q.marker <= 1'b1;
					end
				end else if (pos_q < POS_ACTION) begin
					if (hx.bad) begin
						err_q.offhex <= 1'b1;
					end
					off_q <= {off_q[11:0], hx.value};
				end else if (pos_q == POS_ACTION) begin
					if (rx_byte != ACTION_BYTE) begin
						err_q.action <= 1'b1;
					end
				end else if (pos_q < POS_LAST) begin
					if (hx.bad) begin
						err_q.datahex <= 1'b1;
					end
					// odd positions carry the high nibble
					if (pos_q[0]) begin
						nib_q <= hx.value;
					end else begin
						lo_q <= {hi_q[7:0], lo_q[63:8]};
						hi_q <= {data_byte, hi_q[63:8]};
					end
				end
				if (pos_q < POS_SAT) begin
					pos_q <= pos_q + 6'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ahrp_out_buf.sv =====
// result register with a skid stage so bytes keep flowing while a result waits
`default_nettype none

module ahrp_out_buf
	import ahrp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         can_push,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    main_free;

	assign can_push = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data = main_q;
	assign main_free = !main_valid_q || out_ready;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ascii_hex_record_parser.sv =====
// ascii hex record parser: one byte per cycle while in_ready is high,
// one result word per carriage return, registered in the main or skid register
// two result registers let bytes flow while one waits; in_ready is low while both hold
// reset: arst_n clears record state and valid bits, restores marker and memory size
`default_nettype none

module ascii_hex_record_parser
	import ahrp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      record_offset,
	output logic [63:0]      data_low,
	output logic [63:0]      data_high
);

	logic [31:0] marker_q;
	logic [16:0] memsize_q;
	logic        accept;
	logic        push;
	result_t     res;
	result_t     out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
			memsize_q <= MEMSIZE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MARKER) begin
				marker_q <= cfg_data;
			end else if (cfg_index == CFG_MEMSIZE) begin
				memsize_q <= cfg_data[16:0];
			end
		end
	end

	assign accept = in_valid && in_ready;

	ahrp_field_unit u_field (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.marker_word (marker_q),
		.memory_size (memsize_q),
		.push        (push),
		.result      (res)
	);

	ahrp_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign status = out_res.status;
	assign record_offset = out_res.record_offset;
	assign data_low = out_res.data_low;
	assign data_high = out_res.data_high;

endmodule

`default_nettype wire
